[rtl/ddo_pkg.sv]
// shared constants, types and the arctangent table of the odometry block
package ddo_pkg;

	localparam int unsigned POS_FRAC_BITS_DEF = 16;
	localparam int unsigned CORDIC_STEPS_DEF  = 24;

	localparam logic [31:0] DPC_RESET = 32'd428404;
	localparam logic [23:0] APC_RESET = 24'd72535;

	localparam logic [7:0] REG_DIST_PER_COUNT  = 8'd0;
	localparam logic [7:0] REG_ANGLE_PER_COUNT = 8'd1;

	// cordic gain 0.60725293 as unsigned q0.32
	localparam logic [31:0] CORDIC_GAIN = 32'd2608131496;
	// speed scale: m per us to m per s in q16.16 is 15625 / 1024
	localparam logic [31:0] SPEED_NUM = 32'd15625;

	localparam int unsigned DIV_NUM_W = 77;
	localparam int unsigned DIV_DEN_W = 42;
	localparam int unsigned DIV_Q_W   = 40;

	typedef struct packed {
		logic                 over;
		logic [DIV_Q_W-1:0]   quot;
		logic [DIV_DEN_W-1:0] rem;
	} div_res_t;

	function automatic logic [31:0] atan_at(input logic [4:0] k);
		logic [31:0] v;
		case (k)
			5'd0: v = 32'h20000000;
			5'd1: v = 32'h12E4051E;
			5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;
			5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;
			5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

[rtl/ddo_mul.sv]
// shared registered 32 x 32 unsigned multiplier
module ddo_mul import ddo_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;

endmodule

[rtl/ddo_cordic.sv]
// iterative rotation-mode cordic, one micro-rotation per cycle
module ddo_cordic import ddo_pkg::*; #(
	parameter int unsigned STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] x0,
	input  logic signed [63:0] y0,
	input  logic signed [32:0] z0,
	output logic               done,
	output logic signed [63:0] x,
	output logic signed [63:0] y
);

	localparam int unsigned IW = $clog2(STEPS);

	logic               busy_q;
	logic               done_q;
	logic [IW-1:0]      i_q;
	logic signed [63:0] x_q;
	logic signed [63:0] y_q;
	logic signed [32:0] z_q;

	logic signed [63:0] xs;
	logic signed [63:0] ys;
	logic signed [32:0] at;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = $signed({1'b0, atan_at(5'(i_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == IW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;

endmodule

[rtl/ddo_div.sv]
// restoring divider, one quotient bit per cycle, flags quotient overflow
module ddo_div import ddo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output div_res_t             res
);

	localparam int unsigned KW = $clog2(DIV_NUM_W);

	logic                 busy_q;
	logic                 done_q;
	logic [KW-1:0]        k_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_Q_W-1:0]   quot_q;
	logic                 over_q;

	logic [DIV_DEN_W:0] remsh;
	logic               ge;
	logic               hi;

	assign remsh = {rem_q, num_q[DIV_NUM_W-1]};
	assign ge    = remsh >= {1'b0, den_q};
	assign hi    = k_q >= KW'(DIV_Q_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= KW'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				k_q <= k_q - 1'b1;
				if (k_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
			over_q <= 1'b0;
		end else if (busy_q) begin
			num_q  <= {num_q[DIV_NUM_W-2:0], 1'b0};
			rem_q  <= ge ? DIV_DEN_W'(remsh - {1'b0, den_q}) : DIV_DEN_W'(remsh);
			quot_q <= {quot_q[DIV_Q_W-2:0], ge & ~hi};
			if (ge && hi) begin
				over_q <= 1'b1;
			end
		end
	end

	assign done     = done_q;
	assign res.over = over_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q;

endmodule

[rtl/diff_drive_odometry.sv]
// differential-drive wheel odometry: pose integration and wheel speeds
// Each input transfer carries absolute left/right encoder counts and a microsecond
// stamp; one result transfer follows with the updated pose (x, y in signed fixed
// point with POS_FRAC_BITS fraction bits, heading as a 2^32-per-turn binary angle)
// and both wheel speeds in q16.16 m/s, saturated. Speeds are zero and speed_valid
// is low when the stamp did not advance. The block works on one item at a time
// and drops in_ready while busy. The pose takes one shared 32x32 multiplier, then
// one cordic micro-rotation a cycle; when the stamp advanced, the speeds follow,
// one wheel after the other, through the bit-serial divider that produces 77
// quotient bits per wheel. A finished result waits in the output register while
// the next item is already taken in. Configuration writes are accepted at any
// time but must only be issued while the block is idle.
module diff_drive_odometry import ddo_pkg::*; #(
	parameter int unsigned POS_FRAC_BITS = POS_FRAC_BITS_DEF,
	parameter int unsigned CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	input  logic [31:0]        stamp_us,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [47:0] pos_x,
	output logic signed [47:0] pos_y,
	output logic [31:0]        heading,
	output logic signed [31:0] left_speed,
	output logic signed [31:0] right_speed,
	output logic               speed_valid,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	// working precision is q.30, result rounding shift down to the position format
	localparam int unsigned POS_SHIFT = 30 - POS_FRAC_BITS;
	localparam logic signed [63:0] POS_HALF = 64'sd1 <<< (POS_SHIFT - 1);

	typedef enum logic [16:0] {
		ST_IDLE   = 17'h00001,
		ST_PROD   = 17'h00002,
		ST_MSCALE = 17'h00004,
		ST_GHI    = 17'h00008,
		ST_GLO    = 17'h00010,
		ST_GSUM   = 17'h00020,
		ST_ROT    = 17'h00040,
		ST_CWAIT  = 17'h00080,
		ST_POS    = 17'h00100,
		ST_SPN    = 17'h00200,
		ST_SPMH   = 17'h00400,
		ST_SPML   = 17'h00800,
		ST_SPDIV  = 17'h01000,
		ST_SPDW   = 17'h02000,
		ST_SPRND  = 17'h04000,
		ST_SPSAT  = 17'h08000,
		ST_FIN    = 17'h10000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [31:0] dpc_q;
	logic [23:0] apc_q;

	// persistent odometry state
	logic [31:0] prev_left_q;
	logic [31:0] prev_right_q;
	logic [31:0] prev_stamp_q;
	logic [47:0] acc_x_q;
	logic [47:0] acc_y_q;
	logic [31:0] acc_head_q;

	// per-item working registers
	logic [31:0] dl_q;
	logic [31:0] dr_q;
	logic [31:0] dt_q;
	logic        neg_q;
	logic [32:0] mag_q;
	logic [31:0] h_q;
	logic [61:0] m_q;
	logic [63:0] t_q;
	logic [63:0] dm_q;
	logic [63:0] n_q;
	logic [63:0] p1_q;
	logic        sel_q;
	logic        negw_q;
	logic [40:0] qr_q;
	logic        ovr_q;
	logic [31:0] spd_l_q;
	logic [31:0] spd_r_q;

	// result register
	logic        out_valid_q;
	logic [47:0] out_x_q;
	logic [47:0] out_y_q;
	logic [31:0] out_h_q;
	logic [31:0] out_ls_q;
	logic [31:0] out_rs_q;
	logic        out_sv_q;

	// shared multiplier
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;

	// cordic and divider hookup
	logic               cstart;
	logic signed [63:0] cx0;
	logic signed [63:0] cy0;
	logic signed [32:0] cz0;
	logic               cdone;
	logic signed [63:0] cx;
	logic signed [63:0] cy;
	logic               dstart;
	logic [DIV_NUM_W-1:0] dnum;
	logic                 ddone;
	div_res_t             dres;

	logic [31:0] dl_in;
	logic [31:0] dr_in;
	logic [32:0] sum_in;
	logic [31:0] wd;
	logic [31:0] magw;
	logic [64:0] prod_r;
	logic [63:0] prod;
	logic signed [63:0] r;
	logic [31:0] hq;
	logic [1:0]  quad;
	logic [31:0] zres;
	logic signed [63:0] dx;
	logic signed [63:0] dy;
	logic [40:0] lim;
	logic [40:0] qsat;
	logic [31:0] spd;
	logic        rnd;

	ddo_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	ddo_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cstart),
		.x0     (cx0),
		.y0     (cy0),
		.z0     (cz0),
		.done   (cdone),
		.x      (cx),
		.y      (cy)
	);

	ddo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dstart),
		.num    (dnum),
		.den    ({dt_q, 10'b0}),
		.done   (ddone),
		.res    (dres)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// wrapped count differences and their signed sum magnitude
	assign dl_in  = left_count - prev_left_q;
	assign dr_in  = right_count - prev_right_q;
	assign sum_in = {dl_in[31], dl_in} + {dr_in[31], dr_in};

	// one wheel at a time for the speed path
	assign wd   = sel_q ? dr_q : dl_q;
	assign magw = wd[31] ? (32'd0 - wd) : wd;

	// distance in q.30 before gain: a count sum of 2^32 is a pure shift
	assign prod   = mag_q[32] ? {dpc_q, 32'b0} : mul_p;
	assign prod_r = {1'b0, prod} + 65'd4;

	// quadrant pre-rotation leaves a residual within an eighth turn
	assign r    = neg_q ? -$signed(dm_q) : $signed(dm_q);
	assign hq   = h_q + 32'h2000_0000;
	assign quad = hq[31:30];
	assign zres = h_q - {quad, 30'b0};
	assign cz0  = $signed({zres[31], zres});

	always_comb begin
		case (quad)
			2'd0: begin cx0 = r;  cy0 = '0; end
			2'd1: begin cx0 = '0; cy0 = r;  end
			2'd2: begin cx0 = -r; cy0 = '0; end
			default: begin cx0 = '0; cy0 = -r; end
		endcase
	end

	assign cstart = (state_q == ST_ROT);
	assign dstart = (state_q == ST_SPDIV);
	assign dnum   = DIV_NUM_W'(mul_p) + {p1_q[44:0], 32'b0};

	// round half up to the position format
	assign dx = (cx + POS_HALF) >>> POS_SHIFT;
	assign dy = (cy + POS_HALF) >>> POS_SHIFT;

	// round on remainder, then clamp to the signed q16.16 range
	assign rnd  = ~dres.over & ({dres.rem, 1'b0} >= {1'b0, dt_q, 10'b0});
	assign lim  = negw_q ? 41'h0_8000_0000 : 41'h0_7FFF_FFFF;
	assign qsat = (ovr_q || qr_q > lim) ? lim : qr_q;
	assign spd  = negw_q ? (32'd0 - qsat[31:0]) : qsat[31:0];

	// multiplier operand select, the registered product shows up in the cycle after
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_PROD: begin
				mul_a = mag_q[31:0];
				mul_b = dpc_q;
			end
			ST_MSCALE: begin
				mul_a = dr_q - dl_q;
				mul_b = {8'b0, apc_q};
			end
			ST_GHI: begin
				mul_a = {2'b0, m_q[61:32]};
				mul_b = CORDIC_GAIN;
			end
			ST_GLO: begin
				mul_a = m_q[31:0];
				mul_b = CORDIC_GAIN;
			end
			ST_SPN: begin
				mul_a = magw;
				mul_b = dpc_q;
			end
			ST_SPMH: begin
				mul_a = mul_p[63:32];
				mul_b = SPEED_NUM;
			end
			ST_SPML: begin
				mul_a = n_q[31:0];
				mul_b = SPEED_NUM;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dpc_q        <= DPC_RESET;
			apc_q        <= APC_RESET;
			prev_left_q  <= '0;
			prev_right_q <= '0;
			prev_stamp_q <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			acc_head_q   <= '0;
			sel_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DIST_PER_COUNT) begin
					dpc_q <= cfg_data;
				end else if (cfg_index == REG_ANGLE_PER_COUNT) begin
					apc_q <= cfg_data[23:0];
				end
			end
			// the handover in ST_FIN refills the register itself
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						prev_left_q  <= left_count;
						prev_right_q <= right_count;
						prev_stamp_q <= stamp_us;
						state_q      <= ST_PROD;
					end
				end
				ST_PROD:   state_q <= ST_MSCALE;
				ST_MSCALE: state_q <= ST_GHI;
				ST_GHI: begin
					acc_head_q <= acc_head_q + mul_p[31:0];
					state_q    <= ST_GLO;
				end
				ST_GLO:  state_q <= ST_GSUM;
				ST_GSUM: state_q <= ST_ROT;
				ST_ROT:  state_q <= ST_CWAIT;
				ST_CWAIT: begin
					if (cdone) begin
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					acc_x_q <= acc_x_q + dx[47:0];
					acc_y_q <= acc_y_q + dy[47:0];
					sel_q   <= 1'b0;
					state_q <= (dt_q != '0) ? ST_SPN : ST_FIN;
				end
				ST_SPN:   state_q <= ST_SPMH;
				ST_SPMH:  state_q <= ST_SPML;
				ST_SPML:  state_q <= ST_SPDIV;
				ST_SPDIV: state_q <= ST_SPDW;
				ST_SPDW: begin
					if (ddone) begin
						state_q <= ST_SPRND;
					end
				end
				ST_SPRND: state_q <= ST_SPSAT;
				ST_SPSAT: begin
					sel_q   <= 1'b1;
					state_q <= sel_q ? ST_FIN : ST_SPN;
				end
				ST_FIN: begin
					// hand over once the result register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dl_q    <= dl_in;
				dr_q    <= dr_in;
				dt_q    <= stamp_us - prev_stamp_q;
				neg_q   <= sum_in[32];
				mag_q   <= sum_in[32] ? (33'd0 - sum_in) : sum_in;
				h_q     <= acc_head_q;
				spd_l_q <= '0;
				spd_r_q <= '0;
			end
			ST_MSCALE: m_q  <= prod_r[64:3];
			ST_GLO:    t_q  <= mul_p;
			ST_GSUM:   dm_q <= t_q + {32'b0, mul_p[63:32] + {31'b0, mul_p[31]}};
			ST_SPN:    negw_q <= wd[31];
			ST_SPMH:   n_q  <= mul_p;
			ST_SPML:   p1_q <= mul_p;
			ST_SPRND: begin
				qr_q  <= {1'b0, dres.quot} + {40'b0, rnd};
				ovr_q <= dres.over;
			end
			ST_SPSAT: begin
				if (sel_q) begin
					spd_r_q <= spd;
				end else begin
					spd_l_q <= spd;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_x_q  <= acc_x_q;
					out_y_q  <= acc_y_q;
					out_h_q  <= acc_head_q;
					out_ls_q <= spd_l_q;
					out_rs_q <= spd_r_q;
					out_sv_q <= (dt_q != '0);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign pos_x       = $signed(out_x_q);
	assign pos_y       = $signed(out_y_q);
	assign heading     = out_h_q;
	assign left_speed  = $signed(out_ls_q);
	assign right_speed = $signed(out_rs_q);
	assign speed_valid = out_sv_q;

	// an accepted item keeps the input closed on the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a stalled stamp always reports zero speeds
	a_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !speed_valid) |-> (left_speed == 32'sd0 && right_speed == 32'sd0))
		else $error("nonzero speed with speed_valid low");

	// cordic only finishes while the sequencer waits for it
	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		cdone |-> (state_q == ST_CWAIT))
		else $error("cordic finished outside its wait state");

	// divider only finishes while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		ddone |-> (state_q == ST_SPDW))
		else $error("divider finished outside its wait state");

endmodule

[tb/ddo_checker.sv]
// checker for the odometry block: watches all channels, predicts and compares results
`timescale 1ns / 1ps
module ddo_checker import ddo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	input  logic [31:0]        stamp_us,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [47:0] pos_x,
	input  logic signed [47:0] pos_y,
	input  logic [31:0]        heading,
	input  logic signed [31:0] left_speed,
	input  logic signed [31:0] right_speed,
	input  logic               speed_valid,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic [47:0] x;
		logic [47:0] y;
		logic [31:0] hd;
		logic [31:0] ls;
		logic [31:0] rs;
		logic        sv;
	} pose_t;

	pose_t pose_q[$];

	logic [31:0] dpc, last_l, last_r, last_t, hdg;
	logic [23:0] apc;
	logic [47:0] px, py;

	// floor shift of a signed value
	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [31:0] speed_of(longint d, logic [31:0] dt, logic [31:0] k);
		logic        neg;
		logic [63:0] mag;
		logic [127:0] num, den, q, r, lim;
		neg = d < 0;
		mag = neg ? -d : d;
		num = 128'(mag) * 128'(k) * 128'(15625);
		den = 128'(dt) << 10;
		q = num / den;
		r = num % den;
		if (q < (128'd1 << 40) && (r << 1) >= den)
			q = q + 1;
		lim = neg ? 128'h80000000 : 128'h7FFFFFFF;
		if (q > lim)
			q = lim;
		return neg ? 32'(-q) : 32'(q);
	endfunction

	function automatic pose_t advance(logic [31:0] lc, logic [31:0] rc, logic [31:0] ts);
		pose_t       p;
		longint      dl, dr, sm, rr, x, y, z, xs, ys, dx, dy;
		logic [63:0] mag, prod, m, dm;
		logic [31:0] quad, dt;
		dl = longint'($signed(lc - last_l));
		dr = longint'($signed(rc - last_r));
		dt = ts - last_t;
		sm = dl + dr;
		mag = sm < 0 ? -sm : sm;
		prod = mag * 64'(dpc);
		m = (prod + 4) >> 3;
		dm = (m >> 32) * 64'(CORDIC_GAIN) + (((m & 64'hFFFFFFFF) * 64'(CORDIC_GAIN)
			+ 64'h80000000) >> 32);
		rr = sm < 0 ? -longint'(dm) : longint'(dm);
		quad = ((hdg + 32'h20000000) >> 30) & 3;
		z = longint'($signed(hdg - (quad << 30)));
		case (quad)
			0: begin x = rr; y = 0; end
			1: begin x = 0; y = rr; end
			2: begin x = -rr; y = 0; end
			default: begin x = 0; y = -rr; end
		endcase
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			xs = fshr(x, i);
			ys = fshr(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(atan_at(5'(i)));
			end else begin
				x += ys; y -= xs; z += longint'(atan_at(5'(i)));
			end
		end
		dx = fshr(x + (64'sd1 <<< 13), 14);
		dy = fshr(y + (64'sd1 <<< 13), 14);
		px = px + 48'(dx);
		py = py + 48'(dy);
		hdg = hdg + 32'((dr - dl) * longint'(apc));
		p.x = px;
		p.y = py;
		p.hd = hdg;
		p.sv = dt != 0;
		p.ls = p.sv ? speed_of(dl, dt, dpc) : 32'd0;
		p.rs = p.sv ? speed_of(dr, dt, dpc) : 32'd0;
		last_l = lc;
		last_r = rc;
		last_t = ts;
		return p;
	endfunction

	assign pending = pose_q.size();

	always @(posedge clk or negedge arst_n) begin
		pose_t e;
		if (!arst_n) begin
			dpc = DPC_RESET; apc = APC_RESET;
			last_l = '0; last_r = '0; last_t = '0; hdg = '0; px = '0; py = '0;
			fail_count = 0;
			pose_q.delete();
		end else begin
			// blocking updates of the predicted state inside advance()
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DIST_PER_COUNT)
					dpc = cfg_data;
				else if (cfg_index == REG_ANGLE_PER_COUNT)
					apc = cfg_data[23:0];
			end
			if (in_valid && in_ready)
				pose_q.push_back(advance(left_count, right_count, stamp_us));
			if (out_valid && out_ready) begin
				if (pose_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transfer at %0t", $realtime);
					fail_count = fail_count + 1;
				end else begin
					e = pose_q.pop_front();
					if (e != {pos_x, pos_y, heading, left_speed, right_speed, speed_valid})
						begin
						if (fail_count < 10)
							$display("mismatch exp x=%h y=%h h=%h l=%h r=%h v=%b got x=%h y=%h h=%h l=%h r=%h v=%b",
								e.x, e.y, e.hd, e.ls, e.rs, e.sv,
								pos_x, pos_y, heading, left_speed, right_speed, speed_valid);
						fail_count = fail_count + 1;
					end
				end
			end
		end
	end

endmodule

[tb/diff_drive_odometry_tb.sv]
// top of the odometry testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module diff_drive_odometry_tb import ddo_pkg::*;;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic signed [31:0] left_count = 0, right_count = 0;
	logic [31:0] stamp_us = 0;
	logic signed [47:0] pos_x, pos_y;
	logic [31:0] heading;
	logic signed [31:0] left_speed, right_speed;
	logic speed_valid;
	logic cfg_valid = 0, cfg_ready;
	logic [7:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	int fail_count, pending;
	// idling off during a stretch in the middle of the run
	bit calm = 0;

	// running encoder and time state for well-formed motion
	logic [31:0] enc_l = 0, enc_r = 0, now_us = 0;

	always #5 clk = ~clk;

	diff_drive_odometry dut (.*);

	ddo_checker chk (.*);

	// result side: stall at random except in the calm stretch
	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 38);

	// valid drops after each transfer, the block is busy then anyway
	task automatic send_sample(logic [31:0] l, logic [31:0] r, logic [31:0] t);
		while (!calm && $urandom_range(99) < 38)
			@(posedge clk);
		in_valid <= 1; left_count <= l; right_count <= r; stamp_us <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [31:0] v);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// drain results, then let the block settle before touching registers
	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// plausible motion: small count steps and a positive time step, mostly
	task automatic random_motion();
		int kind;
		kind = $urandom_range(99);
		if (kind < 80) begin
			enc_l = enc_l + 32'($signed($urandom_range(4000)) - 2000);
			enc_r = enc_r + 32'($signed($urandom_range(4000)) - 2000);
			now_us = now_us + $urandom_range(20000, 1);
		end else if (kind < 90) begin
			now_us = now_us + ($urandom_range(3) == 0 ? 0 : $urandom_range(5));
			enc_l = enc_l + $urandom; enc_r = enc_r + $urandom;
		end else begin
			enc_l = $urandom; enc_r = $urandom; now_us = $urandom;
		end
		send_sample(enc_l, enc_r, now_us);
	endtask

	initial begin
		#200_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, zero dt, extremes, wrap of counters and stamp
		send_sample(0, 0, 0);
		send_sample(100, 200, 1000);
		send_sample(100, 200, 1000);
		send_sample(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
		send_sample(32'h80000000, 32'h7FFFFFFF, 0);
		send_sample(32'hFFFFFFFF, 32'hFFFFFFFF, 1);
		send_sample(32'h00001000, 32'hFFFFF000, 2);
		send_sample(32'h55555555, 32'hAAAAAAAA, 32'h55555555);
		send_sample(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
		drain();
		write_reg(REG_DIST_PER_COUNT, 32'hFFFFFFFF);
		write_reg(REG_ANGLE_PER_COUNT, 24'hFFFFFF);
		write_reg(8'hFF, 32'h12345678);
		send_sample(32'h40000000, 32'hC0000000, 32'hAAAAAAAB);
		send_sample(32'h40000001, 32'hC0000003, 32'hAAAAAAAB);
		send_sample(32'hC0000000, 32'h40000000, 32'hAAAAAAAC);
		send_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
		drain();
		write_reg(REG_DIST_PER_COUNT, 0);
		write_reg(REG_ANGLE_PER_COUNT, 0);
		send_sample(5, 9, 3);
		send_sample(32'h80000000, 32'h80000000, 4);
		drain();

		enc_l = 32'h80000000; enc_r = 32'h80000000; now_us = 4;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_reg(REG_DIST_PER_COUNT, DPC_RESET);
					write_reg(REG_ANGLE_PER_COUNT, APC_RESET); end
				1: begin write_reg(REG_DIST_PER_COUNT, $urandom);
					write_reg(REG_ANGLE_PER_COUNT, $urandom_range(24'hFFFFFF)); end
				2: begin write_reg(REG_DIST_PER_COUNT, $urandom_range(2000000));
					write_reg(REG_ANGLE_PER_COUNT, $urandom_range(2000000)); end
				3: begin write_reg(REG_DIST_PER_COUNT, 32'hFFFFFFFF);
					write_reg(REG_ANGLE_PER_COUNT, 24'hFFFFFF); end
				default: begin write_reg(REG_DIST_PER_COUNT, DPC_RESET);
					write_reg(REG_ANGLE_PER_COUNT, $urandom_range(24'hFFFFFF)); end
			endcase
			calm = (ph == 2);
			for (int n = 0; n < 100; n++)
				random_motion();
			drain();
		end
		calm = 0;

		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[diff_drive_odometry.f]
rtl/ddo_pkg.sv
rtl/ddo_mul.sv
rtl/ddo_cordic.sv
rtl/ddo_div.sv
rtl/diff_drive_odometry.sv
tb/ddo_checker.sv
tb/diff_drive_odometry_tb.sv
